// ===== sv/dve_pkg.sv =====
// ============================================================================
// dve_pkg: shared constants for the delta varbyte encoder
// Group size, lead flag, queue depth and default value width used by the
// front, queue, back and top-level modules.
// ============================================================================
`default_nettype none

package dve_pkg;

    // Default width of the IDs that are coded.
    localparam int VALUE_BITS_DEFAULT = 32;

    // Width of the input and output data ports.
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 8;

    // Each code byte carries one group of this many value bits.
    localparam int GROUP_BITS = 7;

    // Bit 7 marks the first byte of a code.
    localparam logic LEAD_FLAG = 1'b1;

    // Number of classified items held between the front and the back.
    localparam int QUEUE_DEPTH = 2;

endpackage : dve_pkg

`default_nettype wire

// ===== sv/dve_queue.sv =====
// ============================================================================
// dve_queue: small register queue between the front and the back
// Holds classified items so that the front can accept a new beat while the
// back is still emitting the bytes of an earlier one.
// ============================================================================
`default_nettype none

module dve_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dve_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    // Handshake on both sides.
    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule : dve_queue

`default_nettype wire

// ===== sv/dve_front.sv =====
// ============================================================================
// dve_front: input stage of the delta varbyte encoder
// Accepts one ID per beat, forms the gap from the previous ID, flags a
// descending ID and finds the index of the most significant nonzero group.
// ============================================================================
`default_nettype none

module dve_front #(
    parameter int VALUE_BITS = dve_pkg::VALUE_BITS_DEFAULT,
    parameter int IDX_W      = 3,
    parameter int ENTRY_W    = 1 + IDX_W + VALUE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dve_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input  wire logic [0:0]                        s_tuser,
    output logic                                   push,
    input  wire logic                              push_ready,
    output logic [ENTRY_W-1:0]                     push_data
);

    localparam int MAX_GROUPS = (VALUE_BITS + dve_pkg::GROUP_BITS - 1) / dve_pkg::GROUP_BITS;
    localparam int PAD_W      = MAX_GROUPS * dve_pkg::GROUP_BITS;

    logic [VALUE_BITS-1:0] prev_reg;
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] coded;
    logic [PAD_W-1:0]      coded_pad;
    logic                  order_error;
    logic [IDX_W-1:0]      top_idx;

    assign s_tready = push_ready;
    assign push     = s_tvalid && push_ready;

    // Gap from the previous ID, or the ID itself at the start of a list.
    assign value       = s_tdata[VALUE_BITS-1:0];
    assign order_error = !s_tuser[0] && (value < prev_reg);
    assign coded       = s_tuser[0] ? value : value - prev_reg;
    assign coded_pad   = PAD_W'(coded);

    // Index of the highest group that holds a set bit; zero codes as one group.
    always_comb
    begin
        top_idx = '0;
        for (int i = 1; i < MAX_GROUPS; i++)
        begin
            if (|coded_pad[i*dve_pkg::GROUP_BITS +: dve_pkg::GROUP_BITS])
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign push_data = {order_error, top_idx, coded};

    // Every accepted ID becomes the reference for the next gap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (push)
        begin
            prev_reg <= value;
        end
    end

endmodule : dve_front

`default_nettype wire

// ===== sv/dve_back.sv =====
// ============================================================================
// dve_back: byte emitter of the delta varbyte encoder
// Takes classified items from the queue and sends their 7-bit groups, most
// significant first, one byte per beat through a registered output.
// ============================================================================
`default_nettype none

module dve_back #(
    parameter int VALUE_BITS = dve_pkg::VALUE_BITS_DEFAULT,
    parameter int IDX_W      = 3,
    parameter int ENTRY_W    = 1 + IDX_W + VALUE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pop_valid,
    output logic                                   pop_ready,
    input  wire logic [ENTRY_W-1:0]                pop_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [dve_pkg::OUT_DATA_BITS-1:0]      m_tdata,
    output logic                                   m_tlast,
    output logic [0:0]                             m_tuser
);

    localparam int MAX_GROUPS = (VALUE_BITS + dve_pkg::GROUP_BITS - 1) / dve_pkg::GROUP_BITS;
    localparam int PAD_W      = MAX_GROUPS * dve_pkg::GROUP_BITS;

    // Item being emitted.
    logic                  cur_valid_reg, cur_valid_next;
    logic [PAD_W-1:0]      coded_reg;
    logic [IDX_W-1:0]      grp_reg, grp_next;
    logic                  err_reg;
    logic                  lead_reg, lead_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [dve_pkg::OUT_DATA_BITS-1:0] out_data_reg;
    logic                  out_last_reg;
    logic                  out_err_reg;

    logic                  out_free;
    logic                  emit;
    logic                  emit_last;
    logic                  pop;
    logic [dve_pkg::GROUP_BITS-1:0] group;

    logic                  entry_err;
    logic [IDX_W-1:0]      entry_idx;
    logic [VALUE_BITS-1:0] entry_coded;

    assign {entry_err, entry_idx, entry_coded} = pop_data;

    // A byte leaves the current item whenever the output register frees up.
    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = cur_valid_reg && out_free;
    assign emit_last = emit && (grp_reg == '0);
    assign pop_ready = !cur_valid_reg || emit_last;
    assign pop       = pop_valid && pop_ready;

    // Select the group to send next.
    always_comb
    begin
        group = coded_reg[dve_pkg::GROUP_BITS-1:0];
        for (int i = 1; i < MAX_GROUPS; i++)
        begin
            if (grp_reg == IDX_W'(i))
            begin
                group = coded_reg[i*dve_pkg::GROUP_BITS +: dve_pkg::GROUP_BITS];
            end
        end
    end

    // Next state of the item tracker and output valid.
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        grp_next       = grp_reg;
        lead_next      = lead_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            grp_next       = entry_idx;
            lead_next      = 1'b1;
        end
        else if (emit)
        begin
            cur_valid_next = !emit_last;
            grp_next       = grp_reg - 1'b1;
            lead_next      = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            grp_reg       <= '0;
            lead_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            grp_reg       <= grp_next;
            lead_reg      <= lead_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the current item and of the output beat.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            coded_reg <= PAD_W'(entry_coded);
            err_reg   <= entry_err;
        end
        if (emit)
        begin
            out_data_reg <= {(lead_reg & dve_pkg::LEAD_FLAG), group};
            out_last_reg <= (grp_reg == '0);
            out_err_reg  <= err_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_err_reg;

endmodule : dve_back

`default_nettype wire

// ===== sv/delta_varbyte_encoder.sv =====
// ============================================================================
// delta_varbyte_encoder: delta-gap variable-byte encoder
// Codes a sorted ID list as gaps, each emitted as 1 to 5 bytes of 7-bit
// groups, most significant group first, with bit 7 set on the lead byte.
// ============================================================================
`default_nettype none

// The block sends one code byte per beat on the output stream, so an ID costs
// 1 to ceil(VALUE_BITS/7) output bytes (1 to 5 at 32 bits) depending on the
// size of its gap; the byte-wide output port sets the sustained rate. Input
// beats are taken whenever the two-entry queue between the classifying front
// and the byte emitter has room, so a new ID can enter while the bytes of
// earlier ones are still leaving. The first ID after reset is coded against a
// previous ID of zero, and order_error marks every byte of a code whose ID was
// below its predecessor within the same list.

module delta_varbyte_encoder #(
    parameter int VALUE_BITS = dve_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dve_pkg::IN_DATA_BITS-1:0]  s_tdata,  // [31:0] value
    input  wire logic [0:0]                        s_tuser,  // [0] first_of_list
    // Output stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [dve_pkg::OUT_DATA_BITS-1:0]      m_tdata,  // [7:0] code_byte
    output logic                                   m_tlast,  // last_of_code
    output logic [0:0]                             m_tuser   // [0] order_error
);

    localparam int MAX_GROUPS = (VALUE_BITS + dve_pkg::GROUP_BITS - 1) / dve_pkg::GROUP_BITS;
    localparam int IDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int ENTRY_W    = 1 + IDX_W + VALUE_BITS;

    logic               push;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    // Gap and top group index for each accepted ID.
    dve_front #(
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue.
    dve_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (dve_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    // Byte emitter with registered output.
    dve_back #(
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule : delta_varbyte_encoder

`default_nettype wire

// ===== bench/delta_varbyte_encoder_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// delta_varbyte_encoder_test: self-checking bench for the delta varbyte encoder
// Drives lists of IDs into the input stream, first a directed table that hits
// every code length and the order error, then random sorted lists with some
// descending and unrelated IDs mixed in. Every code byte that leaves the block
// is compared against hand-typed bytes or a gap encoder that runs beside it.
// ============================================================================

module delta_varbyte_encoder_test;

    localparam int RANDOM_IDS = 350;
    localparam int MAX_CODE_BYTES = 5;
    localparam logic [7:0] LEAD_BIT = 8'h80;
    localparam logic [31:0] GROUP_MASK = 32'h7F;

    // One expected output beat.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       err;
    } code_byte_t;

    // One input beat. When nbytes is nonzero the code is typed in by hand,
    // with the first byte in the low bits of codes.
    typedef struct {
        logic [31:0] id;
        logic        first;
        int          nbytes;
        logic [39:0] codes;
        logic        err;
    } id_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [dve_pkg::IN_DATA_BITS-1:0] s_tdata = '0;     // [31:0] value
    logic [0:0] s_tuser = '0;                           // [0] first_of_list
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [dve_pkg::OUT_DATA_BITS-1:0] m_tdata;         // [7:0] code_byte
    logic m_tlast;                                      // last_of_code
    logic [0:0] m_tuser;                                // [0] order_error

    // Gap encoder state and bookkeeping.
    logic [31:0] last_id = '0;
    code_byte_t code_bytes_due[$];
    id_row_t ids_in_flight[$];
    int fail_count = 0;
    int ids_sent = 0;
    int lists_started = 0;
    int bytes_checked = 0;
    int error_bytes = 0;
    int burst_left = 0;

    // Directed table: edges of every code length, zero gaps and wrap-around.
    id_row_t dir_table [20] = '{
        '{32'h0000_0000, 1'b0, 1, 40'h80, 1'b0},           // after reset, gap zero
        '{32'h0000_007F, 1'b0, 1, 40'hFF, 1'b0},
        '{32'h0000_0080, 1'b0, 1, 40'h81, 1'b0},
        '{32'h0000_0080, 1'b1, 2, 40'h0081, 1'b0},
        '{32'h0000_3FFF, 1'b1, 2, 40'h7FFF, 1'b0},
        '{32'h0000_4000, 1'b1, 3, 40'h000081, 1'b0},
        '{32'h001F_FFFF, 1'b1, 3, 40'h7F7FFF, 1'b0},
        '{32'h0020_0000, 1'b1, 4, 40'h00000081, 1'b0},
        '{32'h0FFF_FFFF, 1'b1, 4, 40'h7F7F7FFF, 1'b0},
        '{32'h1000_0000, 1'b1, 5, 40'h0000000081, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 5, 40'h7F7F7F7F8F, 1'b0},
        '{32'h0000_0000, 1'b0, 1, 40'h81, 1'b1},           // descending, gap wraps
        '{32'hFFFF_FFFF, 1'b0, 5, 40'h7F7F7F7F8F, 1'b0},
        '{32'h0000_0000, 1'b1, 1, 40'h80, 1'b0},           // new list skips compare
        '{32'h1234_5678, 1'b0, 0, 40'h0, 1'b0},
        '{32'h1234_5678, 1'b0, 1, 40'h80, 1'b0},
        '{32'h1234_0000, 1'b0, 0, 40'h0, 1'b0},
        '{32'hAAAA_AAAA, 1'b1, 0, 40'h0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 0, 40'h0, 1'b0},
        '{32'h5555_5555, 1'b1, 0, 40'h0, 1'b0}
    };

    delta_varbyte_encoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // Codes one ID against the last one seen and returns its byte count.
    function automatic int gap_encode(input logic [31:0] id, input logic first,
                                      output code_byte_t codes [MAX_CODE_BYTES]);
        logic [31:0] gap;
        logic        wrapped;
        int          n;
        begin
            wrapped = 1'b0;
            gap = id;
            if (!first)
            begin
                wrapped = (id < last_id);
                gap = id - last_id;
            end
            last_id = id;
            n = 1;
            for (int k = 1; k < MAX_CODE_BYTES; k++)
            begin
                if ((gap >> (dve_pkg::GROUP_BITS * k)) != 0)
                    n = k + 1;
            end
            for (int k = 0; k < MAX_CODE_BYTES; k++)
            begin
                codes[k].code = 8'(((gap >> ((n - 1 - k) * dve_pkg::GROUP_BITS)) & GROUP_MASK));
                if (k == 0)
                    codes[k].code = codes[k].code | LEAD_BIT;
                codes[k].last = (k == n - 1);
                codes[k].err = wrapped;
            end
            return n;
        end
    endfunction

    // A random ID whose code takes the given number of bytes (0 gives zero).
    function automatic logic [31:0] sized_value(input int nbytes);
        case (nbytes)
            0: return 32'h0;
            1: return $urandom_range(1, 32'h7F);
            2: return $urandom_range(32'h80, 32'h3FFF);
            3: return $urandom_range(32'h4000, 32'h1F_FFFF);
            4: return $urandom_range(32'h20_0000, 32'h0FFF_FFFF);
            default: return $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
        endcase
    endfunction

    // Offers one ID until it is taken, then keeps the burst going or idles.
    task automatic send_id(input id_row_t row);
        s_tvalid <= 1'b1;
        s_tdata <= row.id;
        s_tuser <= row.first;
        ids_in_flight.insert(ids_in_flight.size(), row);
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        ids_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 7);
        end
    endtask

    // Receiver: m_tready follows a stall style that is redrawn at random from four.
    always @(negedge clk)
    begin : receiver
        int cyc;
        int mode;
        if (cyc % 50 == 0)
            mode = $urandom_range(0, 3);
        cyc++;
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cyc % 4 == 0);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Expected bytes are queued when an ID is taken and checked as they leave.
    always @(posedge clk)
    begin : scoreboard
        code_byte_t pred [MAX_CODE_BYTES];
        code_byte_t want;
        code_byte_t typed_byte;
        id_row_t row;
        int n;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                n = gap_encode(s_tdata, s_tuser[0], pred);
                if (s_tuser[0])
                    lists_started++;
                row = ids_in_flight.pop_front();
                if (row.nbytes != 0)
                begin
                    for (int k = 0; k < row.nbytes; k++)
                    begin
                        typed_byte.code = row.codes[8*k +: 8];
                        typed_byte.last = (k == row.nbytes - 1);
                        typed_byte.err  = row.err;
                        code_bytes_due.insert(code_bytes_due.size(), typed_byte);
                    end
                end
                else
                begin
                    for (int k = 0; k < n; k++)
                        code_bytes_due.insert(code_bytes_due.size(), pred[k]);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (code_bytes_due.size() == 0)
                begin
                    $error("code byte %02h with no byte expected", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = code_bytes_due.pop_front();
                    bytes_checked++;
                    if (m_tuser[0])
                        error_bytes++;
                    if (m_tdata !== want.code)
                    begin
                        $error("code_byte: expected %02h, got %02h", want.code, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_code: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.err)
                    begin
                        $error("order_error: expected %0b, got %0b", want.err, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random lists.
    initial
    begin : stimulus
        logic [31:0] cur;
        logic [31:0] gap;
        int items_left;
        int list_left;
        int pick;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (dir_table[i])
            send_id(dir_table[i]);

        // Mostly ascending lists; some descending IDs and stray values.
        items_left = RANDOM_IDS;
        while (items_left > 0)
        begin
            list_left = $urandom_range(1, 12);
            cur = ($urandom_range(0, 3) == 0) ? $urandom : sized_value($urandom_range(0, 5));
            send_id('{cur, 1'b1, 0, 40'h0, 1'b0});
            items_left--;
            list_left--;
            while (list_left > 0 && items_left > 0)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 17)
                begin
                    gap = sized_value($urandom_range(0, 5));
                    if (gap > ~cur)
                        gap = ~cur;
                    cur = cur + gap;
                end
                else if (pick < 19 && cur != 0)
                    cur = $urandom_range(0, cur - 1);
                else
                    cur = $urandom;
                send_id('{cur, 1'b0, 0, 40'h0, 1'b0});
                items_left--;
                list_left--;
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray beat.
        while (code_bytes_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d IDs in %0d lists, checked %0d code bytes (%0d with order_error).",
                 ids_sent, lists_started, bytes_checked, error_bytes);
        $display("All code lengths from one to five bytes, wrapped gaps and list restarts.");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin : watchdog
        #4_000_000;
        $display("Timeout with %0d code bytes still expected.", code_bytes_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
